// ===== sv/ctd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the countdown timer with microsecond counter
package ctd_pkg;

  // item kinds carried in the mode field
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // software register map
  typedef enum logic [3:0] {
    REG_CTL      = 4'd0,
    REG_PRESCALE = 4'd1,
    REG_CNT_LO   = 4'd2,
    REG_CNT_HI   = 4'd3,
    REG_LATCH    = 4'd4,
    REG_USEC0    = 4'd5,
    REG_USEC1    = 4'd6,
    REG_USEC2    = 4'd7,
    REG_USEC3    = 4'd8,
    REG_TICK0    = 4'd9,
    REG_TICK1    = 4'd10,
    REG_TICK2    = 4'd11,
    REG_TICK3    = 4'd12
  } reg_idx_e;

  // configuration port register indexes
  typedef enum logic {
    CFG_CLK_PER_USEC = 1'b0,
    CFG_CLK_PER_TICK = 1'b1
  } cfg_idx_e;

  // control register bit positions
  localparam int unsigned CtlEn     = 0;
  localparam int unsigned CtlRepeat = 1;
  localparam int unsigned CtlIrqEn  = 2;
  localparam int unsigned CtlZero   = 3;
  localparam int unsigned CtlIrqFlg = 4;

  // latch control bit positions
  localparam int unsigned LatchUsec = 0;
  localparam int unsigned LatchTick = 1;
  localparam int unsigned ClrUsec   = 2;
  localparam int unsigned ClrTick   = 3;

  localparam logic [7:0]  UsecDivReset = 8'd7;
  localparam logic [15:0] TickDivReset = 16'd1;
  localparam logic [7:0]  NoBits       = 8'h00;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] reg_index;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } out_word_t;

  // per-cycle commands to a free-running counter
  typedef struct packed {
    logic tick;
    logic latch;
    logic clear;
  } cnt_ctl_t;

endpackage

// ===== sv/ctd_freecnt.sv =====
`timescale 1ns / 1ps
// free-running 32-bit counter with clock divider and software latch
module ctd_freecnt #(
  parameter int unsigned DIV_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctd_pkg::cnt_ctl_t ctl_i,
  input  logic [DIV_W-1:0]  limit_i,
  output logic [31:0]       latch_o
);
  import ctd_pkg::*;

  logic [DIV_W-1:0] div_q, div_d;
  logic [31:0]      cnt_q, cnt_d;
  logic [31:0]      latch_q, latch_d;
  logic [DIV_W-1:0] lim_eff;
  logic [DIV_W:0]   div_inc;
  logic             wrap;

  // a setting of zero behaves as one
  assign lim_eff = (limit_i == '0) ? DIV_W'(1) : limit_i;
  assign div_inc = {1'b0, div_q} + (DIV_W + 1)'(1);
  assign wrap    = (div_inc >= {1'b0, lim_eff});

  always_comb begin
    div_d   = div_q;
    cnt_d   = cnt_q;
    latch_d = latch_q;
    if (ctl_i.tick) begin
      if (wrap) begin
        div_d = '0;
        cnt_d = cnt_q + 32'd1;
      end else begin
        div_d = div_inc[DIV_W-1:0];
      end
    end
    // latch sees the value before a clear in the same write
    if (ctl_i.latch) begin
      latch_d = cnt_q;
    end
    if (ctl_i.clear) begin
      div_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      cnt_q   <= '0;
      latch_q <= '0;
    end else begin
      div_q   <= div_d;
      cnt_q   <= cnt_d;
      latch_q <= latch_d;
    end
  end

  assign latch_o = latch_q;

endmodule

// ===== sv/ctd_core.sv =====
`timescale 1ns / 1ps
// timer register file, countdown logic and read mux for one word per cycle while fire_i is high
module ctd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  ctd_pkg::in_word_t  item_i,
  input  logic [7:0]         clocks_per_usec_i,
  input  logic [15:0]        clocks_per_tick_i,
  output ctd_pkg::out_word_t result_o
);
  import ctd_pkg::*;

  logic [4:0]  ctl_q, ctl_d;
  logic [7:0]  ps_q, ps_d;
  logic [7:0]  pc_q, pc_d;
  logic [15:0] reload_q, reload_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  staged_q, staged_d;
  cnt_ctl_t    usec_ctl, tick_ctl;
  logic [31:0] usec_latch, tick_latch;
  logic [1:0]  byte_sel;
  logic [7:0]  rd_byte;

  ctd_freecnt #(.DIV_W(8)) u_usec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (usec_ctl),
    .limit_i (clocks_per_usec_i),
    .latch_o (usec_latch)
  );

  ctd_freecnt #(.DIV_W(16)) u_tick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tick_ctl),
    .limit_i (clocks_per_tick_i),
    .latch_o (tick_latch)
  );

  // byte lanes 5..8 and 9..12 both map to index bits minus one
  assign byte_sel = item_i.reg_index[1:0] - 2'd1;

  always_comb begin
    case (reg_idx_e'(item_i.reg_index))
      REG_CTL:      rd_byte = {3'b000, ctl_q};
      REG_PRESCALE: rd_byte = ps_q;
      REG_CNT_LO:   rd_byte = cnt_q[7:0];
      REG_CNT_HI:   rd_byte = cnt_q[15:8];
      REG_USEC0, REG_USEC1, REG_USEC2, REG_USEC3:
        rd_byte = usec_latch[{byte_sel, 3'b000} +: 8];
      REG_TICK0, REG_TICK1, REG_TICK2, REG_TICK3:
        rd_byte = tick_latch[{byte_sel, 3'b000} +: 8];
      default:      rd_byte = NoBits;
    endcase
  end

  always_comb begin
    ctl_d    = ctl_q;
    ps_d     = ps_q;
    pc_d     = pc_q;
    reload_d = reload_q;
    cnt_d    = cnt_q;
    staged_d = staged_q;
    usec_ctl = '0;
    tick_ctl = '0;
    if (fire_i) begin
      case (mode_e'(item_i.mode))
        MODE_TICK: begin
          usec_ctl.tick = 1'b1;
          tick_ctl.tick = 1'b1;
          if (ctl_q[CtlEn]) begin
            if (pc_q >= ps_q) begin
              pc_d = '0;
              if (cnt_q <= 16'd1) begin
                ctl_d[CtlZero]   = 1'b1;
                ctl_d[CtlIrqFlg] = 1'b1;
                if (ctl_q[CtlRepeat]) begin
                  cnt_d = reload_q;
                end else begin
                  cnt_d        = '0;
                  ctl_d[CtlEn] = 1'b0;
                end
              end else begin
                cnt_d = cnt_q - 16'd1;
              end
            end else begin
              pc_d = pc_q + 8'd1;
            end
          end
        end
        MODE_WRITE: begin
          case (reg_idx_e'(item_i.reg_index))
            REG_CTL: begin
              // writing one to the flag bit clears both sticky bits
              ctl_d[2:0] = item_i.write_data[2:0];
              if (item_i.write_data[CtlIrqFlg]) begin
                ctl_d[CtlZero]   = 1'b0;
                ctl_d[CtlIrqFlg] = 1'b0;
              end
            end
            REG_PRESCALE: begin
              ps_d = item_i.write_data;
              pc_d = '0;
            end
            REG_CNT_LO: staged_d = item_i.write_data;
            REG_CNT_HI: begin
              reload_d = {item_i.write_data, staged_q};
              cnt_d    = {item_i.write_data, staged_q};
              pc_d     = '0;
            end
            REG_LATCH: begin
              usec_ctl.latch = item_i.write_data[LatchUsec];
              tick_ctl.latch = item_i.write_data[LatchTick];
              usec_ctl.clear = item_i.write_data[ClrUsec];
              tick_ctl.clear = item_i.write_data[ClrTick];
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      ps_q     <= '0;
      pc_q     <= '0;
      reload_q <= '0;
      cnt_q    <= '0;
      staged_q <= '0;
    end else begin
      ctl_q    <= ctl_d;
      ps_q     <= ps_d;
      pc_q     <= pc_d;
      reload_q <= reload_d;
      cnt_q    <= cnt_d;
      staged_q <= staged_d;
    end
  end

  assign result_o.read_data = (mode_e'(item_i.mode) == MODE_READ) ? rd_byte : NoBits;
  assign result_o.irq_line  = ctl_d[CtlIrqEn] & ctl_d[CtlIrqFlg];

endmodule

// ===== sv/countdown_timer_with_usec_counter.sv =====
`timescale 1ns / 1ps
// top level of the countdown timer with microsecond and tick counters
// byte-wide timer peripheral driven one word at a time: each input word is a
// clock tick, a register read or a register write, and each produces exactly
// one output word carrying the read byte (zero unless a read) and the irq line
// as it stands after that word. a word is taken into an input register, then
// the register file, both free-running counters and the countdown are updated
// in the same cycle as the result is loaded into an output register. one
// word is accepted per clock when the output side keeps up, and a word's result
// shows on the output when the word moves on from the input register. the input
// stalls only while the output register is full and its word is not taken.
// clocks_per_usec and clocks_per_tick are written through the separate config
// port (index 0 and 1) and reset to 7 and 1; a setting of zero acts as one
module countdown_timer_with_usec_counter (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input word channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ctd_pkg::in_word_t  in_word_i,
  // output word channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ctd_pkg::out_word_t out_word_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import ctd_pkg::*;

  logic      in_valid_q;
  in_word_t  in_q;
  logic      out_valid_q;
  out_word_t out_q;
  logic      fwd_ready;
  logic      fire;
  out_word_t result;
  logic [7:0]  clk_per_usec_q;
  logic [15:0] clk_per_tick_q;

  // output register can take a word when empty or being drained
  assign fwd_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && fwd_ready;
  assign in_stall_o = in_valid_q && !fwd_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  // config registers; the user must write them only while the block is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_per_usec_q <= UsecDivReset;
      clk_per_tick_q <= TickDivReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLK_PER_USEC: clk_per_usec_q <= cfg_data_i[7:0];
        CFG_CLK_PER_TICK: clk_per_tick_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state update and result for the word in the input register
  ctd_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .item_i            (in_q),
    .clocks_per_usec_i (clk_per_usec_q),
    .clocks_per_tick_i (clk_per_tick_q),
    .result_o          (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fwd_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // a processed word always lands in the output register
  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed word did not reach the output register");

  // input stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled without output back-pressure");

  // a drained output with nothing behind it goes empty
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_valid_q) |=> !out_valid_o)
    else $error("output word repeated after being taken");

endmodule

// ===== tb/countdown_timer_with_usec_counter_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the countdown timer with microsecond and tick counters
module countdown_timer_with_usec_counter_tb;
  import ctd_pkg::*;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 190;
  localparam int unsigned HoldCycles    = 60;   // long output hold-off
  localparam int unsigned MaxShown      = 10;   // mismatches printed in full
  localparam int unsigned SettleCycles  = 4;    // block latency plus margin
  localparam bit          Typed         = 1'b1; // expected word typed into the table
  localparam bit          Predicted     = 1'b0; // expected word from the predictor

  // register indexes outside the map, single-bit masks for control and an all-bits latch mask
  localparam logic [3:0] RegSpare   = 4'd13;
  localparam logic [3:0] RegTop     = 4'd15;
  localparam logic [7:0] EnMask     = 8'h01 << CtlEn;
  localparam logic [7:0] RepeatMask = 8'h01 << CtlRepeat;
  localparam logic [7:0] IrqEnMask  = 8'h01 << CtlIrqEn;
  localparam logic [7:0] FlagMask   = 8'h01 << CtlIrqFlg;
  localparam logic [7:0] LatchAll   = (8'h01 << LatchUsec) | (8'h01 << LatchTick) |
                                      (8'h01 << ClrUsec) | (8'h01 << ClrTick);

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [15:0] cfg_data;

  countdown_timer_with_usec_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // timer predictor: own copy of the configuration and of every state register
  // ---------------------------------------------------------------------------
  logic [7:0]  usec_rate;
  logic [15:0] tick_rate;
  logic [4:0]  ctl_bits;
  logic [7:0]  pre_set;
  logic [7:0]  pre_cnt;
  logic [15:0] reload;
  logic [15:0] count;
  logic [7:0]  lo_stage;
  logic [7:0]  usec_div;
  logic [31:0] usec_cnt;
  logic [31:0] usec_snap;
  logic [15:0] tick_div;
  logic [31:0] tick_cnt;
  logic [31:0] tick_snap;

  out_word_t   owed_words[$];  // words the block still owes, oldest first
  int unsigned mismatches;
  bit          idle_on;        // random gaps and stalls allowed
  bit          hold_req;       // asks the receiver for one long hold-off

  // advance the predicted timer by one input word, return the word it should produce
  function automatic out_word_t step_timer(in_word_t w);
    out_word_t   res;
    int unsigned lim;
    res.read_data = NoBits;
    case (w.mode)
      MODE_TICK: begin
        // a divider setting of zero behaves like one
        lim = (usec_rate == 0) ? 1 : usec_rate;
        if (usec_div + 1 >= lim) begin
          usec_div = '0;
          usec_cnt = usec_cnt + 32'd1;
        end else begin
          usec_div = usec_div + 8'd1;
        end
        lim = (tick_rate == 0) ? 1 : tick_rate;
        if (tick_div + 1 >= lim) begin
          tick_div = '0;
          tick_cnt = tick_cnt + 32'd1;
        end else begin
          tick_div = tick_div + 16'd1;
        end
        if (ctl_bits[CtlEn]) begin
          if (pre_cnt >= pre_set) begin
            pre_cnt = '0;
            // a step from one or from zero sets zero and flag, then reloads in repeat mode or stops at zero
            if (count <= 16'd1) begin
              ctl_bits[CtlZero]   = 1'b1;
              ctl_bits[CtlIrqFlg] = 1'b1;
              if (ctl_bits[CtlRepeat]) begin
                count = reload;
              end else begin
                count = '0;
                ctl_bits[CtlEn] = 1'b0;
              end
            end else begin
              count = count - 16'd1;
            end
          end else begin
            pre_cnt = pre_cnt + 8'd1;
          end
        end
      end
      MODE_READ: begin
        case (w.reg_index)
          REG_CTL:      res.read_data = {3'b000, ctl_bits};
          REG_PRESCALE: res.read_data = pre_set;
          REG_CNT_LO:   res.read_data = count[7:0];
          REG_CNT_HI:   res.read_data = count[15:8];
          REG_USEC0:    res.read_data = usec_snap[7:0];
          REG_USEC1:    res.read_data = usec_snap[15:8];
          REG_USEC2:    res.read_data = usec_snap[23:16];
          REG_USEC3:    res.read_data = usec_snap[31:24];
          REG_TICK0:    res.read_data = tick_snap[7:0];
          REG_TICK1:    res.read_data = tick_snap[15:8];
          REG_TICK2:    res.read_data = tick_snap[23:16];
          REG_TICK3:    res.read_data = tick_snap[31:24];
          default:      res.read_data = NoBits;  // latch control and spare indexes
        endcase
      end
      MODE_WRITE: begin
        case (w.reg_index)
          REG_CTL: begin
            // writing one to the flag bit clears both flag and zero
            if (w.write_data[CtlIrqFlg]) begin
              ctl_bits[CtlZero]   = 1'b0;
              ctl_bits[CtlIrqFlg] = 1'b0;
            end
            ctl_bits[CtlEn]     = w.write_data[CtlEn];
            ctl_bits[CtlRepeat] = w.write_data[CtlRepeat];
            ctl_bits[CtlIrqEn]  = w.write_data[CtlIrqEn];
          end
          REG_PRESCALE: begin
            pre_set = w.write_data;
            pre_cnt = '0;
          end
          REG_CNT_LO: lo_stage = w.write_data;
          REG_CNT_HI: begin
            reload  = {w.write_data, lo_stage};
            count   = reload;
            pre_cnt = '0;
          end
          REG_LATCH: begin
            // latch first, so a latch with a reset keeps the old value
            if (w.write_data[LatchUsec]) usec_snap = usec_cnt;
            if (w.write_data[LatchTick]) tick_snap = tick_cnt;
            if (w.write_data[ClrUsec]) begin
              usec_cnt = '0;
              usec_div = '0;
            end
            if (w.write_data[ClrTick]) begin
              tick_cnt = '0;
              tick_div = '0;
            end
          end
          default: ;  // latch bytes and spare indexes ignore writes
        endcase
      end
      default: ;  // nop word
    endcase
    res.irq_line = ctl_bits[CtlIrqEn] & ctl_bits[CtlIrqFlg];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // directed stimulus table
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    bit        fixed;
    out_word_t res;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void add_row(mode_e m, logic [3:0] r, logic [7:0] d,
                                  bit fixed, logic [7:0] rd, logic irq);
    stim_row_t row;
    row.w.mode       = m;
    row.w.reg_index  = r;
    row.w.write_data = d;
    row.fixed        = fixed;
    row.res.read_data = rd;
    row.res.irq_line  = irq;
    stim_rows.push_back(row);
  endfunction

  // random word, weighted so the countdown gets loaded, enabled and runs out often
  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned sub;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 9);
    w.reg_index  = 4'($urandom_range(0, 15));
    w.write_data = 8'($urandom_range(0, 255));
    if (pick < 45) begin
      w.mode = MODE_TICK;
    end else if (pick < 70) begin
      w.mode = MODE_READ;
    end else if (pick < 95) begin
      w.mode = MODE_WRITE;
      case (sub)
        0, 1, 2: begin
          w.reg_index = REG_CTL;
          if ($urandom_range(0, 1) != 0) w.write_data[CtlEn] = 1'b1;
        end
        3: begin
          w.reg_index = REG_PRESCALE;
          if ($urandom_range(0, 3) != 0) w.write_data = 8'($urandom_range(0, 3));
        end
        4: begin
          w.reg_index = REG_CNT_LO;
          if ($urandom_range(0, 3) != 0) w.write_data = 8'($urandom_range(0, 24));
        end
        5: begin
          w.reg_index = REG_CNT_HI;
          if ($urandom_range(0, 4) != 0) w.write_data = NoBits;
        end
        6, 7: w.reg_index = REG_LATCH;
        default: ;  // any index, any byte
      endcase
    end else begin
      w.mode = MODE_NOP;
    end
    return w;
  endfunction

  task automatic flag_mismatch(string what, out_word_t due, out_word_t got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("mismatch %0d (%s): expected rd=%02h irq=%0b, got rd=%02h irq=%0b",
               mismatches, what, due.read_data, due.irq_line, got.read_data, got.irq_line);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driving tasks, all inputs change on the falling edge
  // ---------------------------------------------------------------------------

  // offer one word, optionally after a random gap, and log its expected result
  task automatic send_word(in_word_t w, bit fixed, out_word_t res);
    out_word_t guess;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i) in_valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    // hold the word until the block takes it
    do @(posedge clk_i); while (in_stall);
    guess = step_timer(w);
    owed_words.push_back(fixed ? res : guess);
  endtask

  // stop offering and wait until every owed word has come back
  task automatic wait_all_due();
    @(negedge clk_i) in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
  endtask

  // one config register write, only while the block is idle
  task automatic write_cfg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_CLK_PER_USEC) usec_rate = val[7:0];
    else tick_rate = val;
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard limit on run length, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long hold so the block fills up and stalls its input
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output checker: each taken word against the oldest owed word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t due;
    if (rst_ni && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        flag_mismatch("word with nothing owed", '0, out_word);
      end else begin
        due = owed_words.pop_front();
        if (due.read_data !== out_word.read_data || due.irq_line !== out_word.irq_line) begin
          flag_mismatch("field mismatch", due, out_word);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned usec_plan[NumPhases];
    int unsigned tick_plan[NumPhases];
    stim_row_t   row;
    out_word_t   none;

    // every input known from time zero
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLK_PER_USEC;
    cfg_data  = '0;
    none      = '0;
    mismatches = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;

    // predictor reset state, config at its reset values
    usec_rate = UsecDivReset;
    tick_rate = TickDivReset;
    ctl_bits  = '0;
    pre_set   = '0;
    pre_cnt   = '0;
    reload    = '0;
    count     = '0;
    lo_stage  = '0;
    usec_div  = '0;
    usec_cnt  = '0;
    usec_snap = '0;
    tick_div  = '0;
    tick_cnt  = '0;
    tick_snap = '0;

    // config per random phase: divide-by-zero, the extremes, then ordinary rates
    usec_plan = '{0, 1, 255, 3, $urandom_range(1, 255), 2};
    tick_plan = '{0, 1, 65535, 5, $urandom_range(1, 300), 16};

    // directed part: reset values, spare indexes, nop, countdown to zero in
    // one-shot mode, flag clear, full-scale count, latch combined with reset
    add_row(MODE_READ,  REG_CTL,      8'h00, Typed, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_PRESCALE, 8'h00, Typed, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_CNT_HI,   8'h00, Typed, 8'h00, 1'b0);
    add_row(MODE_READ,  RegTop,       8'hFF, Typed, 8'h00, 1'b0);
    add_row(MODE_NOP,   RegTop,       8'hFF, Typed, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_LATCH,    8'h00, Typed, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_PRESCALE, 8'h00, Typed, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CNT_LO,   8'h02, Typed, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CNT_HI,   8'h00, Typed, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CTL,      EnMask | IrqEnMask, Typed, 8'h00, 1'b0);
    add_row(MODE_TICK,  REG_CTL,      8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_TICK,  REG_CTL,      8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_CTL,      8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_TICK,  RegSpare,     8'hA5, Predicted, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CTL,      FlagMask | IrqEnMask, Typed, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_PRESCALE, 8'hFF, Predicted, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CNT_LO,   8'hFF, Predicted, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CNT_HI,   8'hFF, Predicted, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_CNT_LO,   8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_CTL,      EnMask | RepeatMask | IrqEnMask,
            Predicted, 8'h00, 1'b0);
    add_row(MODE_TICK,  REG_CTL,      8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_LATCH,    LatchAll, Predicted, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_USEC0,    8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_READ,  REG_TICK0,    8'h00, Predicted, 8'h00, 1'b0);
    add_row(MODE_WRITE, REG_USEC3,    8'hAA, Predicted, 8'h00, 1'b0);

    // hold reset, then release it on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_word(row.w, row.fixed, row.res);
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      // new rates only once the block is drained and settled
      wait_all_due();
      repeat (SettleCycles) @(posedge clk_i);
      // upper byte of the usec write is junk that the block must drop
      write_cfg(CFG_CLK_PER_USEC, {8'($urandom_range(0, 255)), 8'(usec_plan[ph])});
      write_cfg(CFG_CLK_PER_TICK, 16'(tick_plan[ph]));
      // the final phase runs with no gaps and no stalls
      if (ph == NumPhases - 1) idle_on = 1'b0;
      for (int unsigned k = 0; k < ItemsPerPhase; k++) begin
        if (ph == 2 && k == 60) hold_req = 1'b1;
        if (ph == 3 && k == 80) wait_all_due();
        send_word(rand_word(), Predicted, none);
      end
    end

    wait_all_due();
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ctd_pkg.sv
sv/ctd_freecnt.sv
sv/ctd_core.sv
sv/countdown_timer_with_usec_counter.sv
tb/countdown_timer_with_usec_counter_tb.sv
